FILE: rtl/rhc_pkg.sv
package rhc_pkg;

    // Field format
    localparam int FIELD_W   = 20;
    localparam int FRAC_BITS = 16;

    localparam logic signed [FIELD_W-1:0] FIELD_MAX = {1'b0, {(FIELD_W-1){1'b1}}};
    localparam logic signed [FIELD_W-1:0] FIELD_MIN = {1'b1, {(FIELD_W-1){1'b0}}};

    // Divider: quotient bits cover hue (up to 1.0) and unsaturated saturation
    localparam int QUO_W = (FRAC_BITS + 1 > FIELD_W - 1) ? FRAC_BITS + 1 : FIELD_W - 1;
    localparam int REM_W = FIELD_W + ((FRAC_BITS > QUO_W) ? FRAC_BITS : QUO_W);

    // Direction register codes
    localparam logic DIR_RGB2HSV = 1'b0;
    localparam logic DIR_HSV2RGB = 1'b1;

    // Channel that holds the maximum
    typedef enum logic [1:0] {
        HUE_R = 2'b00,
        HUE_G = 2'b01,
        HUE_B = 2'b10
    } hue_sect_t;

    // Per-word control carried alongside the divider stages
    typedef struct packed {
        logic                       dir;
        logic                       neg;
        hue_sect_t                  hsect;
        logic                       hue_zero;
        logic                       sat_zero;
        logic                       sat_ovf;
        logic signed [FIELD_W-1:0]  mx;
    } side_t;

endpackage

FILE: rtl/rhc_cfg_if.sv
interface rhc_cfg_if;
    logic valid;
    logic ready;
    logic direction;

    modport source (output valid, output direction, input ready);
    modport sink   (input valid, input direction, output ready);
endinterface

FILE: rtl/rhc_in_if.sv
interface rhc_in_if;
    logic                                valid;
    logic                                ready;
    logic signed [rhc_pkg::FIELD_W-1:0]  chan_a;
    logic signed [rhc_pkg::FIELD_W-1:0]  chan_b;
    logic signed [rhc_pkg::FIELD_W-1:0]  chan_c;

    modport source (output valid, output chan_a, output chan_b, output chan_c, input ready);
    modport sink   (input valid, input chan_a, input chan_b, input chan_c, output ready);
endinterface

FILE: rtl/rhc_out_if.sv
interface rhc_out_if;
    logic                                valid;
    logic                                ready;
    logic signed [rhc_pkg::FIELD_W-1:0]  out_a;
    logic signed [rhc_pkg::FIELD_W-1:0]  out_b;
    logic signed [rhc_pkg::FIELD_W-1:0]  out_c;

    modport source (output valid, output out_a, output out_b, output out_c, input ready);
    modport sink   (input valid, input out_a, input out_b, input out_c, output ready);
endinterface

FILE: rtl/rgb_hsv_converter_core.sv
// RGB <-> HSV pixel converter, signed Q3.16 on all fields.
// Channels: pix (input words: chan_a/b/c), res (result words: out_a/b/c),
// cfg (one-bit direction write: 0 = RGB to HSV, 1 = HSV to RGB).
// All use valid/ready; a word moves on a clock edge with both high.
// cfg is always ready; write it only while no pixel is in flight.
// Throughput: one pixel per clock. The pipeline is a chain of registered
// stages: two setup stages, one stage per quotient bit of the two
// restoring dividers (19 bits), and the output register.
// HSV to RGB runs its multiplies in the first divider stages and rides
// along the rest of the chain, so both directions have the same latency.
// Stall: when the output word is held (valid, not ready), the whole chain
// freezes and pix.ready drops; nothing is lost or repeated.
// Reset clears all stage valid bits and sets direction to RGB to HSV.
module rgb_hsv_converter_core (
    input  logic         clk,
    input  logic         rst_n,
    rhc_cfg_if.sink      cfg,
    rhc_in_if.sink       pix,
    rhc_out_if.source    res
);

    localparam int W   = rhc_pkg::FIELD_W;
    localparam int F   = rhc_pkg::FRAC_BITS;
    localparam int QW  = rhc_pkg::QUO_W;
    localparam int RW  = rhc_pkg::REM_W;
    localparam int IW  = W - F;
    localparam int XW  = W + 2;
    localparam int OW  = ((F + 2 > XW) ? F + 2 : XW);
    localparam int PW  = W + OW;
    localparam int HW  = QW + 4;
    localparam int SW  = 64;

    // Sector modulo-6 by reciprocal
    localparam int SECT_OFS = 6 * ((2 ** (IW - 1) + 5) / 6);
    localparam int M6_SH    = IW + 7;
    localparam int M6_RCP   = (2 ** M6_SH + 5) / 6;
    localparam int M6_W     = IW + 1 + M6_SH;

    localparam logic signed [OW-1:0]  ONE_O  = OW'(1) << F;
    localparam logic signed [F+1:0]   ONE_F  = (F + 2)'(1) << F;
    localparam logic signed [HW-1:0]  ONE_H  = HW'(1) << F;
    localparam logic signed [HW-1:0]  TWO_H  = HW'(2) << F;
    localparam logic signed [HW-1:0]  FOUR_H = HW'(4) << F;
    localparam logic signed [HW-1:0]  SIX_H  = HW'(6) << F;
    localparam logic signed [SW-1:0]  SAT_HI = SW'(rhc_pkg::FIELD_MAX);
    localparam logic signed [SW-1:0]  SAT_LO = SW'(rhc_pkg::FIELD_MIN);

    function automatic logic [W-1:0] sat_fld(input logic signed [SW-1:0] x);
        logic [W-1:0] y;
        if (x > SAT_HI)
            y = rhc_pkg::FIELD_MAX;
        else if (x < SAT_LO)
            y = rhc_pkg::FIELD_MIN;
        else
            y = x[W-1:0];
        return y;
    endfunction

    // Direction register
    logic dir_reg;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            dir_reg <= rhc_pkg::DIR_RGB2HSV;
        else if (cfg.valid)
            dir_reg <= cfg.direction;
    end

    // Global advance: whole chain moves unless the output word is held
    logic res_vld_reg;
    logic advance;

    assign advance   = !res_vld_reg || res.ready;
    assign pix.ready = advance;

    // ---------------- Stage A: min/max, hue numerator, HSV s*f products
    logic signed [W-1:0]    in_r, in_g, in_b;
    logic signed [W-1:0]    a_mx_next, a_mn_next;
    rhc_pkg::hue_sect_t     a_hsect_next;
    logic signed [W:0]      a_num, a_dfull;
    logic [W-1:0]           a_mag_next;
    logic [F-1:0]           a_f;
    logic signed [IW-1:0]   a_ip;
    logic [IW:0]            a_ipofs, a_q6, a_r6;
    logic [M6_W-1:0]        a_m6prod;
    logic signed [F+1:0]    a_omf;
    logic signed [W+F:0]    a_sf_next;
    logic signed [W+F+1:0]  a_st_next;

    assign in_r = pix.chan_a;
    assign in_g = pix.chan_b;
    assign in_b = pix.chan_c;

    always_comb
    begin
        a_mx_next = in_r;
        if (in_g > a_mx_next)
            a_mx_next = in_g;
        if (in_b > a_mx_next)
            a_mx_next = in_b;
        a_mn_next = in_r;
        if (in_g < a_mn_next)
            a_mn_next = in_g;
        if (in_b < a_mn_next)
            a_mn_next = in_b;

        // red tested first, then green
        if (a_mx_next == in_r)
            a_hsect_next = rhc_pkg::HUE_R;
        else if (a_mx_next == in_g)
            a_hsect_next = rhc_pkg::HUE_G;
        else
            a_hsect_next = rhc_pkg::HUE_B;

        case (a_hsect_next)
            rhc_pkg::HUE_R: a_num = (W + 1)'(in_g) - (W + 1)'(in_b);
            rhc_pkg::HUE_G: a_num = (W + 1)'(in_b) - (W + 1)'(in_r);
            default:        a_num = (W + 1)'(in_r) - (W + 1)'(in_g);
        endcase

        a_dfull    = (W + 1)'(a_mx_next) - (W + 1)'(a_mn_next);
        a_mag_next = a_num[W] ? W'(-a_num) : a_num[W-1:0];
    end

    // HSV: fraction, sector (Euclidean mod 6 of the integer part)
    always_comb
    begin
        a_f      = in_r[F-1:0];
        a_ip     = in_r[W-1:F];
        a_ipofs  = (IW + 1)'(a_ip) + (IW + 1)'(SECT_OFS);
        a_m6prod = M6_W'(a_ipofs) * M6_W'(M6_RCP);
        a_q6     = a_m6prod[M6_SH +: (IW + 1)];
        a_r6     = a_ipofs - (IW + 1)'(a_q6 * (IW + 1)'(6));
        a_omf    = ONE_F - {2'b00, a_f};
        a_sf_next = in_g * $signed({1'b0, a_f});
        a_st_next = in_g * a_omf;
    end

    logic                   a_vld_reg;
    logic                   a_dir_reg;
    logic signed [W-1:0]    a_mx_reg;
    logic [W-1:0]           a_d_reg;
    logic                   a_neg_reg;
    rhc_pkg::hue_sect_t     a_hsect_reg;
    logic [W-1:0]           a_mag_reg;
    logic signed [W+F:0]    a_sf_reg;
    logic signed [W+F+1:0]  a_st_reg;
    logic signed [OW-1:0]   a_omp_reg;
    logic signed [W-1:0]    a_v_reg;
    logic [2:0]             a_sect_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            a_vld_reg <= 1'b0;
        else if (advance)
            a_vld_reg <= pix.valid;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            a_dir_reg   <= dir_reg;
            a_mx_reg    <= a_mx_next;
            a_d_reg     <= a_dfull[W-1:0];
            a_neg_reg   <= a_num[W];
            a_hsect_reg <= a_hsect_next;
            a_mag_reg   <= a_mag_next;
            a_sf_reg    <= a_sf_next;
            a_st_reg    <= a_st_next;
            a_omp_reg   <= ONE_O - OW'(in_g);
            a_v_reg     <= in_b;
            a_sect_reg  <= a_r6[2:0];
        end
    end

    // ---------------- Stage B: divider setup (index 0), HSV 1 - x terms
    logic [RW-1:0]          rem_h_reg [0:QW];
    logic [RW-1:0]          rem_s_reg [0:QW];
    logic [W-1:0]           dsr_h_reg [0:QW];
    logic [W-1:0]           dsr_s_reg [0:QW];
    logic [QW-1:0]          q_h_reg   [0:QW];
    logic [QW-1:0]          q_s_reg   [0:QW];
    rhc_pkg::side_t         side_reg  [0:QW];
    logic                   vld_reg   [0:QW];

    logic [RW-1:0]          b_rem_s_next;
    logic [W-1:0]           b_dsr_s_next;
    rhc_pkg::side_t         b_side_next;

    always_comb
    begin
        b_rem_s_next = RW'(a_d_reg) << F;
        b_dsr_s_next = (a_mx_reg > 0) ? a_mx_reg : W'(1);
        b_side_next.dir      = a_dir_reg;
        b_side_next.neg      = a_neg_reg;
        b_side_next.hsect    = a_hsect_reg;
        b_side_next.hue_zero = (a_d_reg == '0);
        b_side_next.sat_zero = !(a_mx_reg > 0);
        b_side_next.sat_ovf  = (b_rem_s_next >= (RW'(b_dsr_s_next) << (W - 1)));
        b_side_next.mx       = a_mx_reg;
    end

    logic signed [OW-1:0]   b_omq_reg, b_omt_reg, b_omp_reg;
    logic signed [W-1:0]    b_v_reg;
    logic [2:0]             b_sect_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg[0] <= 1'b0;
        else if (advance)
            vld_reg[0] <= a_vld_reg;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            rem_h_reg[0] <= RW'(a_mag_reg) << F;
            dsr_h_reg[0] <= (a_d_reg == '0) ? W'(1) : a_d_reg;
            rem_s_reg[0] <= b_rem_s_next;
            dsr_s_reg[0] <= b_dsr_s_next;
            q_h_reg[0]   <= '0;
            q_s_reg[0]   <= '0;
            side_reg[0]  <= b_side_next;
            b_omq_reg    <= ONE_O - OW'(a_sf_reg >>> F);
            b_omt_reg    <= ONE_O - OW'(a_st_reg >>> F);
            b_omp_reg    <= a_omp_reg;
            b_v_reg      <= a_v_reg;
            b_sect_reg   <= a_sect_reg;
        end
    end

    // ---------------- Divider chain: stage k resolves quotient bit QW-k
    genvar k;
    generate
        for (k = 1; k <= QW; k++)
        begin : g_div
            logic [RW-1:0] trial_h, trial_s;
            logic          ge_h, ge_s;

            assign trial_h = RW'(dsr_h_reg[k-1]) << (QW - k);
            assign trial_s = RW'(dsr_s_reg[k-1]) << (QW - k);
            assign ge_h    = (rem_h_reg[k-1] >= trial_h);
            assign ge_s    = (rem_s_reg[k-1] >= trial_s);

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                    vld_reg[k] <= 1'b0;
                else if (advance)
                    vld_reg[k] <= vld_reg[k-1];
            end

            always_ff @(posedge clk)
            begin
                if (advance)
                begin
                    rem_h_reg[k] <= ge_h ? rem_h_reg[k-1] - trial_h : rem_h_reg[k-1];
                    rem_s_reg[k] <= ge_s ? rem_s_reg[k-1] - trial_s : rem_s_reg[k-1];
                    q_h_reg[k]   <= {q_h_reg[k-1][QW-2:0], ge_h};
                    q_s_reg[k]   <= {q_s_reg[k-1][QW-2:0], ge_s};
                    dsr_h_reg[k] <= dsr_h_reg[k-1];
                    dsr_s_reg[k] <= dsr_s_reg[k-1];
                    side_reg[k]  <= side_reg[k-1];
                end
            end
        end
    endgenerate

    // ---------------- HSV to RGB: products, then select and saturate
    logic signed [PW-1:0]   hp_p_reg, hp_q_reg, hp_t_reg;
    logic [2:0]             hp_sect_reg;
    logic [W-1:0]           hs_a_reg [2:QW];
    logic [W-1:0]           hs_b_reg [2:QW];
    logic [W-1:0]           hs_c_reg [2:QW];
    logic [W-1:0]           hv_v, hv_p, hv_q, hv_t;
    logic [W-1:0]           hs_a_next, hs_b_next, hs_c_next;

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            hp_p_reg    <= b_v_reg * b_omp_reg;
            hp_q_reg    <= b_v_reg * b_omq_reg;
            hp_t_reg    <= b_v_reg * b_omt_reg;
            hp_sect_reg <= b_sect_reg;
        end
    end

    logic signed [W-1:0] hp_v_reg;

    always_ff @(posedge clk)
    begin
        if (advance)
            hp_v_reg <= b_v_reg;
    end

    always_comb
    begin
        hv_v = hp_v_reg;
        hv_p = sat_fld(SW'(hp_p_reg >>> F));
        hv_q = sat_fld(SW'(hp_q_reg >>> F));
        hv_t = sat_fld(SW'(hp_t_reg >>> F));
        case (hp_sect_reg)
            3'd0:
            begin
                hs_a_next = hv_v; hs_b_next = hv_t; hs_c_next = hv_p;
            end
            3'd1:
            begin
                hs_a_next = hv_q; hs_b_next = hv_v; hs_c_next = hv_p;
            end
            3'd2:
            begin
                hs_a_next = hv_p; hs_b_next = hv_v; hs_c_next = hv_t;
            end
            3'd3:
            begin
                hs_a_next = hv_p; hs_b_next = hv_q; hs_c_next = hv_v;
            end
            3'd4:
            begin
                hs_a_next = hv_t; hs_b_next = hv_p; hs_c_next = hv_v;
            end
            default:
            begin
                hs_a_next = hv_v; hs_b_next = hv_p; hs_c_next = hv_q;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            hs_a_reg[2] <= hs_a_next;
            hs_b_reg[2] <= hs_b_next;
            hs_c_reg[2] <= hs_c_next;
        end
    end

    genvar j;
    generate
        for (j = 3; j <= QW; j++)
        begin : g_hsv_dly
            always_ff @(posedge clk)
            begin
                if (advance)
                begin
                    hs_a_reg[j] <= hs_a_reg[j-1];
                    hs_b_reg[j] <= hs_b_reg[j-1];
                    hs_c_reg[j] <= hs_c_reg[j-1];
                end
            end
        end
    endgenerate

    // ---------------- Output stage: hue fixup, saturation, mux
    rhc_pkg::side_t         e_side;
    logic signed [HW-1:0]   e_qh, e_hq, e_base, e_hsum;
    logic [W-1:0]           e_hue, e_sat;
    logic [W-1:0]           out_a_next, out_b_next, out_c_next;

    always_comb
    begin
        e_side = side_reg[QW];
        e_qh   = $signed({{(HW - QW){1'b0}}, q_h_reg[QW]});
        e_hq   = e_side.neg ? -(e_qh + HW'(rem_h_reg[QW] != '0)) : e_qh;
        case (e_side.hsect)
            rhc_pkg::HUE_R: e_base = '0;
            rhc_pkg::HUE_G: e_base = TWO_H;
            default:        e_base = FOUR_H;
        endcase
        e_hsum = e_base + e_hq;
        if (e_hsum < 0)
            e_hsum = e_hsum + SIX_H;
        e_hue = e_side.hue_zero ? '0 : sat_fld(SW'(e_hsum));

        if (e_side.sat_zero)
            e_sat = '0;
        else if (e_side.sat_ovf)
            e_sat = rhc_pkg::FIELD_MAX;
        else
            e_sat = {1'b0, q_s_reg[QW][W-2:0]};

        if (e_side.dir == rhc_pkg::DIR_RGB2HSV)
        begin
            out_a_next = e_hue;
            out_b_next = e_sat;
            out_c_next = e_side.mx;
        end
        else
        begin
            out_a_next = hs_a_reg[QW];
            out_b_next = hs_b_reg[QW];
            out_c_next = hs_c_reg[QW];
        end
    end

    logic [W-1:0] out_a_reg, out_b_reg, out_c_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            res_vld_reg <= 1'b0;
        else if (advance)
            res_vld_reg <= vld_reg[QW];
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_a_reg <= out_a_next;
            out_b_reg <= out_b_next;
            out_c_reg <= out_c_next;
        end
    end

    assign res.valid = res_vld_reg;
    assign res.out_a = out_a_reg;
    assign res.out_b = out_b_reg;
    assign res.out_c = out_c_reg;

`ifndef SYNTHESIS
    // hue remainder ends below the divisor
    a_hue_rem: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[QW] |-> (rem_h_reg[QW] < RW'(dsr_h_reg[QW])))
        else $error("hue divider remainder not reduced");

    // hue quotient magnitude never exceeds one
    a_hue_quo: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[QW] && !side_reg[QW].hue_zero |-> (q_h_reg[QW] <= QW'(ONE_H)))
        else $error("hue quotient above one");

    // RGB to HSV results: hue and saturation are never negative
    a_hs_sign: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[QW] && advance && side_reg[QW].dir == rhc_pkg::DIR_RGB2HSV
        |=> (!out_a_reg[W-1] && !out_b_reg[W-1]))
        else $error("negative hue or saturation");
`endif

endmodule

FILE: verif/rhc_checker.sv
`timescale 1ns / 1ps

module rhc_checker (
    input  logic  clk,
    input  logic  rst_n,
    rhc_cfg_if    cfg,
    rhc_in_if     pix,
    rhc_out_if    res,
    output int    fail_count,
    output int    pending,
    output int    results_seen
);

    localparam longint ONE_Q = longint'(1) << rhc_pkg::FRAC_BITS;

    typedef struct {
        logic signed [rhc_pkg::FIELD_W-1:0] a;
        logic signed [rhc_pkg::FIELD_W-1:0] b;
        logic signed [rhc_pkg::FIELD_W-1:0] c;
    } pixel_t;

    pixel_t expected_pixels[$];
    logic   conv_dir;

    function automatic longint fdiv(longint n, longint d);
        longint q;
        q = n / d;
        if ((n % d) != 0 && n < 0)
            q = q - 1;
        return q;
    endfunction

    function automatic logic signed [rhc_pkg::FIELD_W-1:0] clamp(longint x);
        if (x > longint'(rhc_pkg::FIELD_MAX))
            return rhc_pkg::FIELD_MAX;
        if (x < longint'(rhc_pkg::FIELD_MIN))
            return rhc_pkg::FIELD_MIN;
        return x[rhc_pkg::FIELD_W-1:0];
    endfunction

    function automatic pixel_t convert_pixel(logic d, longint a, longint b, longint c);
        pixel_t o;
        longint mx, mn, sp, h, s, f, ip, sect, p, q, t, ra, rb, rc;
        if (d == rhc_pkg::DIR_RGB2HSV)
        begin
            mx = a; mn = a; h = 0;
            if (b > mx) mx = b;
            if (c > mx) mx = c;
            if (b < mn) mn = b;
            if (c < mn) mn = c;
            sp = mx - mn;
            if (sp > 0)
            begin
                if (mx == a)
                    h = fdiv((b - c) * ONE_Q, sp);
                else if (mx == b)
                    h = 2 * ONE_Q + fdiv((c - a) * ONE_Q, sp);
                else
                    h = 4 * ONE_Q + fdiv((a - b) * ONE_Q, sp);
                if (h < 0)
                    h = h + 6 * ONE_Q;
            end
            s = (mx > 0) ? fdiv(sp * ONE_Q, mx) : 0;
            ra = h; rb = s; rc = mx;
        end
        else
        begin
            f = a & (ONE_Q - 1);
            ip = fdiv(a - f, ONE_Q);
            sect = ip % 6;
            if (sect < 0)
                sect = sect + 6;
            p = fdiv(c * (ONE_Q - b), ONE_Q);
            q = fdiv(c * (ONE_Q - fdiv(b * f, ONE_Q)), ONE_Q);
            t = fdiv(c * (ONE_Q - fdiv(b * (ONE_Q - f), ONE_Q)), ONE_Q);
            case (sect)
                0: begin ra = c; rb = t; rc = p; end
                1: begin ra = q; rb = c; rc = p; end
                2: begin ra = p; rb = c; rc = t; end
                3: begin ra = p; rb = q; rc = c; end
                4: begin ra = t; rb = p; rc = c; end
                default: begin ra = c; rb = p; rc = q; end
            endcase
        end
        o.a = clamp(ra); o.b = clamp(rb); o.c = clamp(rc);
        return o;
    endfunction

    assign pending = expected_pixels.size();

    // track direction, predict on input, compare on output
    always @(posedge clk or negedge rst_n)
    begin
        pixel_t e;
        if (!rst_n)
        begin
            conv_dir <= rhc_pkg::DIR_RGB2HSV;
            fail_count <= 0;
            results_seen <= 0;
            expected_pixels.delete();
        end
        else
        begin
            if (cfg.valid && cfg.ready)
                conv_dir <= cfg.direction;
            if (pix.valid && pix.ready)
                expected_pixels.push_back(convert_pixel(conv_dir, pix.chan_a, pix.chan_b,
                    pix.chan_c));
            if (res.valid && res.ready)
            begin
                results_seen <= results_seen + 1;
                if (expected_pixels.size() == 0)
                begin
                    $display("%0t: unexpected result word %0d %0d %0d", $time,
                        res.out_a, res.out_b, res.out_c);
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    e = expected_pixels.pop_front();
                    if (e.a !== res.out_a || e.b !== res.out_b || e.c !== res.out_c)
                    begin
                        $display("%0t: mismatch expected %0d %0d %0d actual %0d %0d %0d",
                            $time, e.a, e.b, e.c, res.out_a, res.out_b, res.out_c);
                        fail_count <= fail_count + 1;
                    end
                end
            end
        end
    end
endmodule

FILE: verif/testbench.sv
`timescale 1ns / 1ps

module testbench;

    localparam int LATENCY = 22;
    localparam longint CYCLE_LIMIT = 400000;

    logic clk;
    logic rst_n;
    int   fail_count, pending, results_seen;
    int   pixels_sent;
    longint cycle_count = 0;

    rhc_cfg_if cfg ();
    rhc_in_if  pix ();
    rhc_out_if res ();

    rgb_hsv_converter_core uut (.clk(clk), .rst_n(rst_n), .cfg(cfg), .pix(pix), .res(res));
    rhc_checker chk (.clk(clk), .rst_n(rst_n), .cfg(cfg), .pix(pix), .res(res),
        .fail_count(fail_count), .pending(pending), .results_seen(results_seen));

    always
    begin
        clk = 1'b0; #2;
        clk = 1'b1; #2;
    end

    // cycle limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("testbench: FAIL");
            $finish;
        end
    end

    // result side: random stall per word
    initial
    begin
        int gap;
        res.ready = 1'b0;
        forever
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
            if (gap != 0)
            begin
                res.ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            res.ready <= 1'b1;
            @(posedge clk);
            while (!res.valid) @(posedge clk);
        end
    end

    task automatic write_direction(logic d);
        cfg.valid <= 1'b1;
        cfg.direction <= d;
        @(posedge clk);
        while (!cfg.ready) @(posedge clk);
        cfg.valid <= 1'b0;
    endtask

    // valid stays high into the next word when there is no gap
    task automatic send_pixel(logic signed [rhc_pkg::FIELD_W-1:0] a,
                              logic signed [rhc_pkg::FIELD_W-1:0] b,
                              logic signed [rhc_pkg::FIELD_W-1:0] c);
        int gap;
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
        if (gap != 0)
        begin
            pix.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        pix.valid <= 1'b1;
        pix.chan_a <= a; pix.chan_b <= b; pix.chan_c <= c;
        @(posedge clk);
        while (!pix.ready) @(posedge clk);
        pixels_sent++;
    endtask

    task automatic drain();
        pix.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (LATENCY + 4) @(posedge clk);
    endtask

    // field value: mostly in-range pixel/hsv numbers, sometimes full-scale
    function automatic logic signed [rhc_pkg::FIELD_W-1:0] rand_field(int lo, int hi);
        if ($urandom_range(0, 4) == 0)
            return rhc_pkg::FIELD_W'($urandom());
        return rhc_pkg::FIELD_W'($urandom_range(hi - lo, 0) + lo);
    endfunction

    task automatic random_pixels(logic d, int n);
        for (int i = 0; i < n; i++)
            if (d == rhc_pkg::DIR_RGB2HSV)
                send_pixel(rand_field(0, 65536), rand_field(0, 65536), rand_field(0, 65536));
            else
                send_pixel(rand_field(-65536, 7 * 65536), rand_field(0, 65536),
                    rand_field(0, 65536));
    endtask

    initial
    begin
        pixels_sent = 0;
        cfg.valid = 1'b0; cfg.direction = 1'b0;
        pix.valid = 1'b0; pix.chan_a = '0; pix.chan_b = '0; pix.chan_c = '0;
        rst_n = 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed, RGB to HSV: gray, each max channel, negatives, extremes
        send_pixel(20'sd32768, 20'sd32768, 20'sd32768);
        send_pixel(20'sd65536, 20'sd0, 20'sd16384);
        send_pixel(20'sd0, 20'sd65536, 20'sd16384);
        send_pixel(20'sd16384, 20'sd0, 20'sd65536);
        send_pixel(20'sd65536, 20'sd65536, 20'sd0);
        send_pixel(-20'sd1000, -20'sd5000, -20'sd2000);
        send_pixel(20'sd1, -20'sd65536, 20'sd0);
        send_pixel(rhc_pkg::FIELD_MAX, rhc_pkg::FIELD_MIN, 20'sd0);
        send_pixel(rhc_pkg::FIELD_MIN, rhc_pkg::FIELD_MIN, rhc_pkg::FIELD_MIN);
        send_pixel(rhc_pkg::FIELD_MAX, rhc_pkg::FIELD_MAX, rhc_pkg::FIELD_MAX);
        send_pixel(20'sd0, 20'sd0, 20'sd0);
        drain();

        // directed, HSV to RGB: every sector, wrapped hue, odd saturation
        write_direction(rhc_pkg::DIR_HSV2RGB);
        for (int k = 0; k < 6; k++)
            send_pixel(rhc_pkg::FIELD_W'(k * 65536 + 20000), 20'sd45000, 20'sd60000);
        send_pixel(-20'sd30000, 20'sd65536, 20'sd65536);
        send_pixel(rhc_pkg::FIELD_MAX, rhc_pkg::FIELD_MAX, rhc_pkg::FIELD_MAX);
        send_pixel(rhc_pkg::FIELD_MIN, rhc_pkg::FIELD_MIN, rhc_pkg::FIELD_MIN);
        send_pixel(20'sd100000, -20'sd65536, rhc_pkg::FIELD_MAX);
        send_pixel(20'sd0, 20'sd0, -20'sd65536);
        drain();

        // random phases alternating direction
        write_direction(rhc_pkg::DIR_RGB2HSV);
        random_pixels(rhc_pkg::DIR_RGB2HSV, 250);
        drain();
        write_direction(rhc_pkg::DIR_HSV2RGB);
        random_pixels(rhc_pkg::DIR_HSV2RGB, 250);
        drain();
        write_direction(rhc_pkg::DIR_RGB2HSV);
        random_pixels(rhc_pkg::DIR_RGB2HSV, 250);
        drain();
        write_direction(rhc_pkg::DIR_HSV2RGB);
        random_pixels(rhc_pkg::DIR_HSV2RGB, 250);
        drain();

        $display("Sent %0d pixels in both directions, %0d results checked.",
            pixels_sent, results_seen);
        if (fail_count == 0 && pending == 0)
            $display("testbench: PASS");
        else
            $display("testbench: FAIL");
        $finish;
    end
endmodule
